>>> rtl/core/mpq_pkg.sv
package mpq_pkg;

   localparam int CAPACITY      = 1024;
   localparam int PRIORITY_BITS = 16;
   localparam int TIME_BITS     = 32;

   localparam int ID_BITS   = 10;
   localparam int ID_COUNT  = 1 << ID_BITS;
   localparam int SLOTS     = (CAPACITY < ID_COUNT) ? CAPACITY : ID_COUNT;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int OCC_BITS  = 11;

   typedef enum logic [2:0] {
      ACT_INSERT  = 3'd0,
      ACT_EXTRACT = 3'd1,
      ACT_CHANGE  = 3'd2,
      ACT_DELETE  = 3'd3,
      ACT_CLEAR   = 3'd4
   } action_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_DUPLICATE = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] pri;
      logic [TIME_BITS-1:0]     tim;
      logic [ID_BITS-1:0]       id;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // True when entry a wins over entry b: higher priority, then earlier
   // time, then lower id.
   function automatic logic beats(input entry_type a, input entry_type b);
      logic res;
      if (a.pri != b.pri) begin
         res = a.pri > b.pri;
      end else if (a.tim != b.tim) begin
         res = a.tim < b.tim;
      end else begin
         res = a.id < b.id;
      end
      return res;
   endfunction

endpackage

>>> rtl/core/max_priority_queue_by_id_unit.sv
// Max priority queue addressed by a 10-bit item id. Each request word carries
// one action (insert, extract max, change priority, delete by id, clear) and
// yields exactly one response word with the extracted id, a status and the
// occupancy after the action. Items are ordered by larger priority, then
// earlier submit time, then lower id, so the extracted item is fully defined.
// The items live in an entry memory packed from slot zero upward, and an id
// map memory gives the slot of each id; an id counts as present only when its
// mapped slot is below the item count and that slot holds the same id, so a
// clear only zeroes the item count. After reset the block first walks the id
// map once with req_stall high. It works on one request at a time. Insert and
// change priority pass the map lookup, entry check and response steps; a delete
// that finds its id also moves the last entry into the freed slot. Clear and
// unused codes go straight to the response step, which waits for as long as the
// response register holds a stalled word. Extract max reads every held entry
// through the single read port of the entry memory, one per cycle. A new request
// is taken while an earlier response word still waits.
module max_priority_queue_by_id_unit
   import mpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_valid,
   output logic          req_stall,
   input  logic [2:0]    req_action,
   input  logic [9:0]    req_item_id,
   input  logic [15:0]   req_item_priority,
   input  logic [31:0]   req_submit_time,

   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [9:0]    rsp_result_id,
   output logic          rsp_result_valid,
   output logic [2:0]    rsp_status,
   output logic [10:0]   rsp_occupancy
);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_LOOK, S_CHK, S_LAST, S_SCAN, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Latched request.
   logic [2:0]               act_ff, act_in;
   logic [ID_BITS-1:0]       id_ff, id_in;
   logic [PRIORITY_BITS-1:0] pri_ff, pri_in;
   logic [TIME_BITS-1:0]     tim_ff, tim_in;

   logic [OCC_BITS-1:0]  count_ff, count_in;
   logic [ID_BITS-1:0]   init_ff, init_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic                 inrange_ff, inrange_in;

   // Extract scan.
   logic [OCC_BITS-1:0]  idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [SLOT_BITS-1:0] pslot_ff, pslot_in;
   entry_type            best_ff, best_in;

   // Staged result and response register.
   logic [ID_BITS-1:0]  st_id_ff, st_id_in;
   logic                st_rv_ff, st_rv_in;
   logic [2:0]          st_status_ff, st_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]  rsp_id_ff, rsp_id_in;
   logic                rsp_rv_ff, rsp_rv_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [OCC_BITS-1:0] rsp_occ_ff, rsp_occ_in;

   // Memory ports.
   logic                 ent_we;
   logic [SLOT_BITS-1:0] ent_waddr, ent_raddr;
   entry_type            ent_wdata, ent_rdata;
   logic [ENTRY_BITS-1:0] ent_rvec;
   logic                 map_we;
   logic [ID_BITS-1:0]   map_waddr, map_raddr;
   logic [OCC_BITS-1:0]  map_wdata, map_rdata;

   logic req_take;
   logic present;
   logic issue;

   mpq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(SLOTS)) u_ent (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rvec)
   );

   mpq_ram #(.WIDTH(OCC_BITS), .DEPTH(ID_COUNT)) u_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   assign ent_rdata = entry_type'(ent_rvec);
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign present   = inrange_ff && (ent_rdata.id == id_ff);
   assign issue     = (idx_ff < count_ff);

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      id_in         = id_ff;
      pri_in        = pri_ff;
      tim_in        = tim_ff;
      count_in      = count_ff;
      init_in       = init_ff;
      slot_in       = slot_ff;
      inrange_in    = inrange_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      pslot_in      = pslot_ff;
      best_in       = best_ff;
      st_id_in      = st_id_ff;
      st_rv_in      = st_rv_ff;
      st_status_in  = st_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_id_in     = rsp_id_ff;
      rsp_rv_in     = rsp_rv_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;

      ent_we    = 1'b0;
      ent_waddr = slot_ff;
      ent_wdata = ent_rdata;
      ent_raddr = slot_ff;
      map_we    = 1'b0;
      map_waddr = id_ff;
      map_wdata = '0;
      map_raddr = req_item_id;

      unique case (state_ff)
         S_INIT: begin
            // Point every id at slot zero so the map never reads unknown.
            map_we    = 1'b1;
            map_waddr = init_ff;
            map_wdata = '0;
            init_in   = init_ff + 1'b1;
            if (init_ff == ID_BITS'(ID_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               act_in       = req_action;
               id_in        = req_item_id;
               pri_in       = PRIORITY_BITS'(req_item_priority);
               tim_in       = TIME_BITS'(req_submit_time);
               st_id_in     = '0;
               st_rv_in     = 1'b0;
               st_status_in = ST_OK;
               unique case (req_action)
                  ACT_INSERT, ACT_CHANGE, ACT_DELETE: begin
                     state_in = S_LOOK;
                  end
                  ACT_EXTRACT: begin
                     if (count_ff == '0) begin
                        st_status_in = ST_EMPTY;
                        state_in     = S_DONE;
                     end else begin
                        idx_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_LOOK: begin
            // Map data is here; fetch the entry it points at.
            slot_in    = map_rdata[SLOT_BITS-1:0];
            inrange_in = (map_rdata < count_ff);
            ent_raddr  = map_rdata[SLOT_BITS-1:0];
            state_in   = S_CHK;
         end
         S_CHK: begin
            state_in = S_DONE;
            unique case (act_ff)
               ACT_INSERT: begin
                  if (present) begin
                     st_status_in = ST_DUPLICATE;
                  end else if (count_ff >= OCC_BITS'(SLOTS)) begin
                     st_status_in = ST_FULL;
                  end else begin
                     ent_we    = 1'b1;
                     ent_waddr = count_ff[SLOT_BITS-1:0];
                     ent_wdata = '{pri: pri_ff, tim: tim_ff, id: id_ff};
                     map_we    = 1'b1;
                     map_waddr = id_ff;
                     map_wdata = count_ff;
                     count_in  = count_ff + 1'b1;
                  end
               end
               ACT_CHANGE: begin
                  if (!present) begin
                     st_status_in = ST_NOT_FOUND;
                  end else begin
                     ent_we    = 1'b1;
                     ent_waddr = slot_ff;
                     ent_wdata = '{pri: pri_ff, tim: ent_rdata.tim, id: id_ff};
                  end
               end
               default: begin
                  // Delete by id.
                  if (!present) begin
                     st_status_in = ST_NOT_FOUND;
                  end else begin
                     ent_raddr = SLOT_BITS'(count_ff - 1'b1);
                     state_in  = S_LAST;
                  end
               end
            endcase
         end
         S_LAST: begin
            // Move the last entry into the freed slot.
            ent_we    = 1'b1;
            ent_waddr = slot_ff;
            ent_wdata = ent_rdata;
            map_we    = 1'b1;
            map_waddr = ent_rdata.id;
            map_wdata = OCC_BITS'(slot_ff);
            count_in  = count_ff - 1'b1;
            state_in  = S_DONE;
         end
         S_SCAN: begin
            ent_raddr = idx_ff[SLOT_BITS-1:0];
            if (issue) begin
               idx_in   = idx_ff + 1'b1;
               pend_in  = 1'b1;
               pslot_in = idx_ff[SLOT_BITS-1:0];
            end
            if (pend_ff) begin
               if (pslot_ff == '0 || beats(ent_rdata, best_ff)) begin
                  best_in = ent_rdata;
                  slot_in = pslot_ff;
               end
            end
            if (!issue && !pend_ff) begin
               st_id_in  = best_ff.id;
               st_rv_in  = 1'b1;
               ent_raddr = SLOT_BITS'(count_ff - 1'b1);
               state_in  = S_LAST;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = st_id_ff;
               rsp_rv_in     = st_rv_ff;
               rsp_status_in = st_status_ff;
               rsp_occ_in    = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= '0;
         init_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         init_ff      <= init_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      id_ff         <= id_in;
      pri_ff        <= pri_in;
      tim_ff        <= tim_in;
      slot_ff       <= slot_in;
      inrange_ff    <= inrange_in;
      idx_ff        <= idx_in;
      pslot_ff      <= pslot_in;
      best_ff       <= best_in;
      st_id_ff      <= st_id_in;
      st_rv_ff      <= st_rv_in;
      st_status_ff  <= st_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_rv_ff     <= rsp_rv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_result_valid = rsp_rv_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_occupancy    = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OCC_BITS'(SLOTS))
      else $error("item count above capacity");

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INIT |-> !rsp_valid_ff)
      else $error("response during id map walk");

   a_result_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rv_ff |-> rsp_status_ff == ST_OK)
      else $error("extracted id with failing status");

   a_drop_dec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LAST |=> count_ff == $past(count_ff) - 1'b1)
      else $error("removal did not shrink the queue");

   a_empty_fast: assert property (@(posedge clock) disable iff (reset)
      req_take && req_action == ACT_EXTRACT && count_ff == '0
      |=> state_ff == S_DONE && st_status_ff == ST_EMPTY)
      else $error("extract on empty queue mishandled");

endmodule

>>> rtl/core/mpq_ram.sv
module mpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [ABITS-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [ABITS-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
